// ===== src/sha1_pkg.sv =====
// SHA-1 byte hasher package: item types, initial hash values, round constants and functions.
// No dependencies.
package sha1_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        word_last;
  } out_item_t;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    begin
      if (r < 7'd20) k = 32'h5A827999;
      else if (r < 7'd40) k = 32'h6ED9EBA1;
      else if (r < 7'd60) k = 32'h8F1BBCDC;
      else k = 32'hCA62C1D6;
      return k;
    end
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    begin
      if (r < 7'd20) f = (b & c) | (~b & d);
      else if (r < 7'd40) f = b ^ c ^ d;
      else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
      else f = b ^ c ^ d;
      return f;
    end
  endfunction

endpackage

// ===== src/sha1_wbuf.sv =====
// SHA-1 message schedule memory: 16 words of 32 bits, byte writes, one
// registered read port. Depends on nothing.
module sha1_wbuf (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [3:0]  wr_addr,
  input  logic [3:0]  wr_be,
  input  logic [31:0] wr_data,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_data
);
  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < 4; i++) begin
        if (wr_be[i]) mem[wr_addr][8*i +: 8] <= wr_data[8*i +: 8];
      end
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== src/sha1_core.sv =====
// SHA-1 compression core: 80 rounds, one per cycle, schedule words read from
// the block memory, then kept in a shift line. Depends on sha1_pkg, sha1_wbuf.
module sha1_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [159:0] h_in,
  output logic [159:0] h_out,
  output logic        done,
  // load port from the byte front end
  input  logic        ld_en,
  input  logic [3:0]  ld_addr,
  input  logic [3:0]  ld_be,
  input  logic [31:0] ld_data
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_ADD  = 3'b100
  } cst_t;

  cst_t        st_r, st_nxt;
  logic [6:0]  rnd_r;
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] w_r [16];
  logic        mem_wr;
  logic [3:0]  rd_addr;
  logic [31:0] rd_data;
  logic [31:0] wx, wt, wnew, t;
  logic [6:0]  rnd_n;

  // schedule kept as a 16-deep shift line; memory supplies first 16 words
  assign rnd_n = rnd_r + 7'd1;
  assign rd_addr = (st_r == S_IDLE) ? 4'd0 : rnd_n[3:0];
  assign wx = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign wnew = {wx[30:0], wx[31]};
  assign wt = (rnd_r < 7'd16) ? rd_data : wnew;
  assign t  = {a_r[26:0], a_r[31:27]} + sha1_pkg::round_f(rnd_r, b_r, c_r, d_r) + e_r +
              sha1_pkg::round_k(rnd_r) + wt;
  assign mem_wr = 1'b0;

  sha1_wbuf u_wbuf (
    .clk(clk), .wr_en(ld_en | mem_wr), .wr_addr(ld_addr), .wr_be(ld_be),
    .wr_data(ld_data), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (start) st_nxt = S_RUN;
      S_RUN:  if (rnd_r == 7'd79) st_nxt = S_ADD;
      S_ADD:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && start) begin
      {a_r, b_r, c_r, d_r, e_r} <= h_in;
      rnd_r <= 7'd0;
    end else if (st_r == S_RUN) begin
      e_r <= d_r;
      d_r <= c_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      b_r <= a_r;
      a_r <= t;
      rnd_r <= rnd_n;
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wt;
    end
  end

  assign h_out = {h_in[159:128] + a_r, h_in[127:96] + b_r, h_in[95:64] + c_r,
                  h_in[63:32] + d_r, h_in[31:0] + e_r};
  assign done  = (st_r == S_ADD);

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> st_r == S_IDLE) else $error("start while busy");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ld_en |-> st_r == S_IDLE) else $error("load while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("done held");
endmodule

// ===== src/sha1_byte_hasher.sv =====
// Streaming SHA-1 hasher. An absorb item writes its byte to the block memory and
// starts a compression when it fills a block; finish writes 16 pad words per padded
// block and compresses it, then gives five items. Throughput: one byte per cycle
// within a block; input stalls while the one-round-per-cycle core compresses a block.
// Reset: synchronous active-low rst_n restores the initial hash values.
// Depends on sha1_pkg, sha1_core.
module sha1_byte_hasher (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sha1_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sha1_pkg::out_item_t  out_data
);
  typedef enum logic [5:0] {
    S_ACC  = 6'b000001,
    S_CMP  = 6'b000010,
    S_PAD  = 6'b000100,
    S_FIN  = 6'b001000,
    S_WAIT = 6'b010000,
    S_OUT  = 6'b100000
  } st_t;

  st_t          st_r, st_nxt;
  logic [159:0] h_r;
  logic [5:0]   fill_r;
  logic [63:0]  bits_r;
  logic         finish_r, last_blk_r;
  logic [3:0]   pad_idx_r;
  logic [2:0]   wcnt_r;
  logic [159:0] digest_r;
  logic         ld_en;
  logic [3:0]   ld_addr, ld_be;
  logic [31:0]  ld_data;
  logic         start;
  logic [159:0] h_out;
  logic         done;
  logic         acc;

  sha1_core u_core (
    .clk(clk), .rst_n(rst_n), .start(start), .h_in(h_r), .h_out(h_out), .done(done),
    .ld_en(ld_en), .ld_addr(ld_addr), .ld_be(ld_be), .ld_data(ld_data)
  );

  assign in_ready = (st_r == S_ACC);
  assign acc = in_valid && in_ready;

  // byte write on absorb, else pad word for word index pad_idx_r, given current fill (bytes pending)
  always_comb begin
    ld_en = 1'b0; ld_addr = 4'd0; ld_be = 4'd0; ld_data = 32'd0;
    if (acc && in_data.cmd == sha1_pkg::CMD_ABSORB) begin
      ld_en   = 1'b1;
      ld_addr = fill_r[5:2];
      ld_be   = 4'b1000 >> fill_r[1:0];
      ld_data = {4{in_data.data_byte}};
    end else if (st_r == S_PAD) begin
      ld_en   = 1'b1;
      ld_addr = pad_idx_r;
      ld_be   = 4'hF;
      if (last_blk_r && pad_idx_r == 4'd14) ld_data = bits_r[63:32];
      else if (last_blk_r && pad_idx_r == 4'd15) ld_data = bits_r[31:0];
      else if (last_blk_r && fill_r >= 6'd56) ld_data = 32'd0;
      else if (pad_idx_r == fill_r[5:2]) begin
        for (int i = 0; i < 4; i++) begin
          if (i[1:0] < fill_r[1:0]) ld_be[3-i] = 1'b0;
          else if (i[1:0] == fill_r[1:0]) ld_data[31-8*i -: 8] = sha1_pkg::PAD_BYTE;
        end
      end else if (pad_idx_r < fill_r[5:2]) ld_be = 4'h0;
    end
  end

  assign start = (st_r == S_PAD && pad_idx_r == 4'd15) ||
                 (st_r == S_CMP);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_ACC: if (acc) begin
        if (in_data.cmd == sha1_pkg::CMD_FINISH) st_nxt = S_PAD;
        else if (fill_r == 6'd63) st_nxt = S_CMP;
      end
      S_CMP:  st_nxt = S_WAIT;
      S_PAD:  if (pad_idx_r == 4'd15) st_nxt = S_WAIT;
      S_WAIT: if (done) st_nxt = S_FIN;
      S_FIN: begin
        if (!finish_r) st_nxt = S_ACC;
        else if (!last_blk_r) st_nxt = S_PAD;
        else st_nxt = S_OUT;
      end
      S_OUT:  if (out_ready && wcnt_r == 3'd4) st_nxt = S_ACC;
      default: st_nxt = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_ACC;
      h_r <= {sha1_pkg::IV0, sha1_pkg::IV1, sha1_pkg::IV2, sha1_pkg::IV3, sha1_pkg::IV4};
      fill_r <= 6'd0;
      bits_r <= 64'd0;
      finish_r <= 1'b0;
      last_blk_r <= 1'b0;
      pad_idx_r <= 4'd0;
      wcnt_r <= 3'd0;
    end else begin
      st_r <= st_nxt;
      if (acc) begin
        pad_idx_r <= 4'd0;
        if (in_data.cmd == sha1_pkg::CMD_ABSORB) begin
          fill_r <= fill_r + 6'd1;
          bits_r <= bits_r + 64'd8;
          finish_r <= 1'b0;
        end else begin
          finish_r <= 1'b1;
          last_blk_r <= (fill_r < 6'd56);
        end
      end
      if (st_r == S_PAD) pad_idx_r <= pad_idx_r + 4'd1;
      if (done) h_r <= h_out;
      if (st_r == S_FIN && finish_r) begin
        if (!last_blk_r) begin
          // second pad block: all zeros then length
          last_blk_r <= 1'b1;
          finish_r <= 1'b1;
          pad_idx_r <= 4'd0;
        end else begin
          digest_r <= h_r;
          wcnt_r <= 3'd0;
        end
      end
      if (st_r == S_OUT && out_ready) begin
        digest_r <= {digest_r[127:0], 32'd0};
        wcnt_r <= wcnt_r + 3'd1;
        if (wcnt_r == 3'd4) begin
          h_r <= {sha1_pkg::IV0, sha1_pkg::IV1, sha1_pkg::IV2, sha1_pkg::IV3,
                  sha1_pkg::IV4};
          fill_r <= 6'd0;
          bits_r <= 64'd0;
          finish_r <= 1'b0;
          last_blk_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid = (st_r == S_OUT);
  assign out_data.digest_word = digest_r[159:128];
  assign out_data.word_last = (wcnt_r == 3'd4);

  a_out_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> wcnt_r <= 3'd4) else $error("word count overflow");
  a_no_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input open during output");
  a_last_ret: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.word_last |=> in_ready) else $error("no return");
endmodule

// ===== sim/sha1_byte_hasher_tb.sv =====
// Testbench for sha1_byte_hasher: drives absorb and finish items, predicts the
// five digest words per message with a SHA-1 model of its own and checks them in order.
// Depends on sha1_pkg and sha1_byte_hasher.
`timescale 1ns / 100ps

module sha1_byte_hasher_tb;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sha1_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sha1_pkg::out_item_t out_data;

  sha1_pkg::in_item_t pending_items[$];
  sha1_pkg::out_item_t digest_queue[$];

  logic [31:0] hash_state[5];
  logic [7:0] msg_block[64];
  logic [5:0] fill;
  logic [63:0] bit_count;

  int errors = 0;
  int idle_cycles = 0;
  int hold_off = 400;
  int sent = 0;
  bit quiet_phase = 1'b0;

  sha1_byte_hasher uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++)
      w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
    for (int r = 16; r < 80; r++)
      w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
    d = hash_state[3]; e = hash_state[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + k + w[r];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
    hash_state[3] += d; hash_state[4] += e;
  endtask

  task automatic restart_message();
    hash_state[0] = sha1_pkg::IV0; hash_state[1] = sha1_pkg::IV1;
    hash_state[2] = sha1_pkg::IV2; hash_state[3] = sha1_pkg::IV3;
    hash_state[4] = sha1_pkg::IV4;
    fill = '0;
    bit_count = '0;
  endtask

  task automatic predict_digest(input sha1_pkg::in_item_t item);
    int i;
    sha1_pkg::out_item_t res;
    if (item.cmd == sha1_pkg::CMD_ABSORB) begin
      msg_block[fill] = item.data_byte;
      bit_count += 64'd8;
      fill = fill + 6'd1;
      if (fill == 6'd0) compress_block();
      return;
    end
    i = fill;
    msg_block[i] = sha1_pkg::PAD_BYTE;
    i = i + 1;
    if (i > 56) begin
      while (i < 64) begin
        msg_block[i] = 8'h00;
        i = i + 1;
      end
      compress_block();
      i = 0;
    end
    while (i < 56) begin
      msg_block[i] = 8'h00;
      i = i + 1;
    end
    for (int j = 0; j < 8; j++) msg_block[56+j] = bit_count[63-8*j -: 8];
    compress_block();
    for (int j = 0; j < 5; j++) begin
      res.digest_word = hash_state[j];
      res.word_last = (j == 4);
      digest_queue.push_back(res);
    end
    restart_message();
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch %s: got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    sha1_pkg::in_item_t it;
    it.cmd = sha1_pkg::CMD_ABSORB;
    it.data_byte = b;
    pending_items.push_back(it);
  endtask

  task automatic add_finish(input logic [7:0] junk);
    sha1_pkg::in_item_t it;
    it.cmd = sha1_pkg::CMD_FINISH;
    it.data_byte = junk;
    pending_items.push_back(it);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_digest(in_data);
        sent <= sent + 1;
      end
      quiet_phase <= (sent >= 100) && (sent < 180);
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && (quiet_phase || $urandom_range(99) >= 22)) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver hold-off
  always @(posedge clk) begin
    if (rst_n && hold_off > 0) hold_off <= hold_off - 1;
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (digest_queue.size() == 0) begin
          report_mismatch("unexpected item", out_data.digest_word, '0);
        end else begin
          sha1_pkg::out_item_t want;
          want = digest_queue.pop_front();
          if (out_data.digest_word !== want.digest_word)
            report_mismatch("digest_word", out_data.digest_word, want.digest_word);
          if (out_data.word_last !== want.word_last)
            report_mismatch("word_last", {31'd0, out_data.word_last},
                            {31'd0, want.word_last});
        end
      end
      if (hold_off > 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet_phase || ($urandom_range(99) >= 22);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sha1_byte_hasher_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int n, lim;
    restart_message();
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty message, "abc", all-ones byte, padding boundaries
    add_finish(8'hFF);
    add_byte(8'h61); add_byte(8'h62); add_byte(8'h63); add_finish(8'h00);
    add_byte(8'hFF); add_byte(8'h00); add_finish(8'hA5);
    add_finish(8'h5A);
    for (int i = 0; i < 55; i++) add_byte(i[7:0]);
    add_finish(8'h00);
    for (int i = 0; i < 56; i++) add_byte(8'hFF - i[7:0]);
    add_finish(8'h00);
    for (int i = 0; i < 64; i++) add_byte(8'($urandom_range(255)));
    add_finish(8'h00);

    // random messages up to the item budget
    n = pending_items.size();
    while (n < 270) begin
      lim = ($urandom_range(9) == 0) ? int'($urandom_range(130)) : int'($urandom_range(12));
      if (lim > 269 - n) lim = 269 - n;
      for (int i = 0; i < lim; i++) add_byte(8'($urandom_range(255)));
      add_finish(8'($urandom_range(255)));
      n += lim + 1;
    end

    wait (pending_items.size() == 0 && in_valid == 1'b0);
    lim = 0;
    while (digest_queue.size() > 0 && lim < 50000) begin
      @(posedge clk);
      lim++;
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && digest_queue.size() == 0) begin
      $display("sha1_byte_hasher_tb: PASS");
    end else begin
      $display("sha1_byte_hasher_tb: FAIL");
    end
    $finish;
  end

endmodule
